@@ sv/gead_pkg.sv @@
// Shared types and constants for the guided edge-aware denoise block.
// No dependencies.
package gead_pkg;

	localparam int COLOR_W  = 36;
	localparam int ALBEDO_W = 36;
	localparam int NORMAL_W = 48;
	localparam int DEPTH_W  = 24;
	localparam int ID_W     = 16;
	localparam int CHAN_W   = 12;

	// configuration register indexes
	localparam logic [2:0] REG_RADIUS    = 3'd0;
	localparam logic [2:0] REG_NCOS      = 3'd1;
	localparam logic [2:0] REG_ALB_SQ    = 3'd2;
	localparam logic [2:0] REG_DEPTH_THR = 3'd3;
	localparam logic [2:0] REG_WIDTH     = 3'd4;
	localparam logic [2:0] REG_HEIGHT    = 3'd5;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_FILTER = 1'b1;

	typedef struct packed {
		logic [ALBEDO_W-1:0] albedo;
		logic [NORMAL_W-1:0] normal;
		logic [DEPTH_W-1:0]  depth;
		logic [ID_W-1:0]     id;
	} guide_t;

	typedef struct packed {
		logic [COLOR_W-1:0] colour;
		guide_t             g;
	} pix_t;

	localparam int PIX_W = $bits(pix_t);

	typedef struct packed {
		logic signed [15:0] ncos;
		logic [25:0]        alb_sq;
		logic [23:0]        depth_thr;
	} thr_t;

	typedef struct packed {
		logic               v;
		logic [COLOR_W-1:0] colour;
	} smp_t;

endpackage

@@ sv/gead_ram.sv @@
// Generic single-clock RAM, one write port, one registered read port.
// No dependencies.
module gead_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/gead_test.sv @@
// Two-stage neighbour test: id, depth, albedo distance and normal cosine.
// Depends on gead_pkg.
module gead_test import gead_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   v,
	input  pix_t   smp,
	input  guide_t cen,
	input  thr_t   thr,
	output smp_t   res
);

	logic               v_s2;
	logic [COLOR_W-1:0] col_s2;
	logic               id_ok_s2, dep_ok_s2;
	logic [23:0]        sq_s2 [3];
	logic signed [31:0] pr_s2 [3];
	logic               v_s3;
	logic [COLOR_W-1:0] col_s3;

	logic [DEPTH_W-1:0] dd;
	logic signed [12:0] da [3];
	logic signed [25:0] dsq [3];
	logic signed [15:0] na [3], nb [3];

	logic [25:0]        alb_dist;
	logic signed [33:0] dot, lim;
	logic               dist_ok, dot_ok;

	always_comb begin
		dd = (smp.g.depth > cen.depth) ? smp.g.depth - cen.depth : cen.depth - smp.g.depth;
		for (int i = 0; i < 3; i++) begin
			da[i] = $signed({1'b0, smp.g.albedo[i*CHAN_W +: CHAN_W]})
				- $signed({1'b0, cen.albedo[i*CHAN_W +: CHAN_W]});
			dsq[i] = da[i] * da[i];
			na[i] = smp.g.normal[i*16 +: 16];
			nb[i] = cen.normal[i*16 +: 16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= v;
			v_s3 <= v_s2 && id_ok_s2 && dep_ok_s2 && dist_ok && dot_ok;
		end
	end

	always_ff @(posedge clk) begin
		col_s2    <= smp.colour;
		id_ok_s2  <= smp.g.id == cen.id;
		dep_ok_s2 <= dd <= thr.depth_thr;
		for (int i = 0; i < 3; i++) begin
			sq_s2[i] <= dsq[i][23:0];
			pr_s2[i] <= na[i] * nb[i];
		end
		col_s3 <= col_s2;
	end

	always_comb begin
		alb_dist = 26'(sq_s2[0]) + 26'(sq_s2[1]) + 26'(sq_s2[2]);
		dot      = 34'(pr_s2[0]) + 34'(pr_s2[1]) + 34'(pr_s2[2]);
		lim      = 34'($signed(thr.ncos)) <<< 14;
		dist_ok  = alb_dist <= thr.alb_sq;
		dot_ok   = !dot[33] && dot >= lim;
	end

	assign res.v      = v_s3;
	assign res.colour = col_s3;

endmodule

@@ sv/gead_div.sv @@
// Three-channel restoring divider, one quotient bit per cycle.
// Depends on gead_pkg.
module gead_div import gead_pkg::*; #(
	parameter int SW  = 22,
	parameter int CNW = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SW-1:0]     num0,
	input  logic [SW-1:0]     num1,
	input  logic [SW-1:0]     num2,
	input  logic [CNW-1:0]    den,
	output logic              busy,
	output logic              done,
	output logic [CHAN_W-1:0] q0,
	output logic [CHAN_W-1:0] q1,
	output logic [CHAN_W-1:0] q2
);

	localparam int STW = $clog2(SW + 1);

	logic [SW-1:0]  n_q [3];
	logic [CNW-1:0] rem_q [3];
	logic [CNW-1:0] den_q;
	logic [STW-1:0] step_q;
	logic           done_q;

	logic [CNW:0]   t [3];
	logic [CNW-1:0] rem_d [3];
	logic           qb [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			t[i] = {rem_q[i], n_q[i][SW-1]};
			qb[i] = t[i] >= {1'b0, den_q};
			rem_d[i] = qb[i] ? CNW'(t[i] - {1'b0, den_q}) : CNW'(t[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			step_q <= STW'(SW);
			done_q <= 1'b0;
		end else if (step_q != '0) begin
			step_q <= step_q - 1'b1;
			if (step_q == STW'(1)) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q[0] <= num0;
			n_q[1] <= num1;
			n_q[2] <= num2;
			for (int i = 0; i < 3; i++) rem_q[i] <= '0;
			den_q <= den;
		end else if (step_q != '0) begin
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= rem_d[i];
				n_q[i]   <= {n_q[i][SW-2:0], qb[i]};
			end
		end
	end

	assign busy = step_q != '0;
	assign done = done_q;
	assign q0   = n_q[0][CHAN_W-1:0];
	assign q1   = n_q[1][CHAN_W-1:0];
	assign q2   = n_q[2][CHAN_W-1:0];

endmodule

@@ sv/guided_edge_aware_denoise.sv @@
// channel | direction | handshake            | payload
// in      | sink      | in_valid/in_ready    | operation, column, row, colour, guide fields
// out     | source    | out_valid/out_ready  | avg_red, avg_green, avg_blue, contributors
// cfg     | sink      | cfg_valid/cfg_ready  | cfg_index, cfg_data
// A load beat is one RAM write. A filter beat takes 1 centre read,
// (2r+1)^2 window reads (one per cycle on the single RAM read port), a drain
// and a divide, then the quotients go to the output register.
// Reset clears control state only; pixel memory is undefined until loaded.
// A finished result waits in the output register; a new beat is taken meanwhile.
// Depends on gead_pkg, gead_ram, gead_test, gead_div.
module guided_edge_aware_denoise import gead_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int MAX_RADIUS = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [7:0]  column,
	input  logic [7:0]  row,
	input  logic [11:0] red,
	input  logic [11:0] green,
	input  logic [11:0] blue,
	input  logic [35:0] albedo_packed,
	input  logic [47:0] normal_packed,
	input  logic [23:0] depth,
	input  logic [15:0] object_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] avg_red,
	output logic [11:0] avg_green,
	output logic [11:0] avg_blue,
	output logic [7:0]  contributors,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [25:0] cfg_data
);

	localparam int DEPTH_N = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW      = $clog2(DEPTH_N);
	localparam int CMAX    = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1;
	localparam int CNW     = $clog2(CMAX + 1);
	localparam int SW      = $clog2(CMAX * 4095 + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CEN   = 3'd1;
	localparam logic [2:0] S_WALK  = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_DIV   = 3'd4;

	logic [2:0]  state_q;
	logic [2:0]  radius_q;
	thr_t        thr_q;
	logic [8:0]  fw_q, fh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q        <= 3'd1;
			thr_q.ncos      <= 16'sd14189;
			thr_q.alb_sq    <= 26'd1024;
			thr_q.depth_thr <= 24'd4096;
			fw_q            <= 9'd256;
			fh_q            <= 9'd256;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RADIUS:    radius_q        <= cfg_data[2:0];
				REG_NCOS:      thr_q.ncos      <= cfg_data[15:0];
				REG_ALB_SQ:    thr_q.alb_sq    <= cfg_data;
				REG_DEPTH_THR: thr_q.depth_thr <= cfg_data[23:0];
				REG_WIDTH:     fw_q            <= cfg_data[8:0];
				REG_HEIGHT:    fh_q            <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	logic [8:0] w, h;
	logic [2:0] r;
	assign w = (32'(fw_q) > MAX_WIDTH)  ? 9'(MAX_WIDTH)  : fw_q;
	assign h = (32'(fh_q) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : fh_q;
	assign r = (32'(radius_q) > MAX_RADIUS) ? 3'(MAX_RADIUS) : radius_q;

	logic acc_in, is_load, load_in, filt_in;
	assign in_ready = state_q == S_IDLE;
	assign acc_in   = in_valid && in_ready;
	assign is_load  = operation == OP_LOAD;
	assign load_in  = acc_in && is_load
		&& 32'(column) < MAX_WIDTH && 32'(row) < MAX_HEIGHT;
	assign filt_in  = acc_in && !is_load && {1'b0, column} < w && {1'b0, row} < h;

	logic [AW-1:0] in_addr;
	assign in_addr = AW'(32'(row) * MAX_WIDTH + 32'(column));

	// window walk
	logic signed [9:0] x_q, y_q, y_beg_q, x_end_q, y_end_q;
	logic              inb, last;
	logic [AW-1:0]     k;
	assign inb  = !x_q[9] && !y_q[9] && x_q < $signed({1'b0, w}) && y_q < $signed({1'b0, h});
	assign last = x_q == x_end_q && y_q == y_end_q;
	assign k    = AW'(32'(y_q[8:0]) * MAX_WIDTH + 32'(x_q[8:0]));

	logic [AW-1:0] raddr;
	pix_t          wdata, rdata;
	assign raddr = (state_q == S_IDLE) ? in_addr : k;
	assign wdata = '{colour: {red, green, blue},
		g: '{albedo: albedo_packed, normal: normal_packed, depth: depth, id: object_id}};

	gead_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH_N)) u_ram (
		.clk   (clk),
		.we    (load_in),
		.waddr (in_addr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	guide_t cen_q;
	logic   rd_v_s1;
	smp_t   res;

	gead_test u_test (
		.clk    (clk),
		.arst_n (arst_n),
		.v      (rd_v_s1),
		.smp    (rdata),
		.cen    (cen_q),
		.thr    (thr_q),
		.res    (res)
	);

	logic [SW-1:0]  sr_q, sg_q, sb_q;
	logic [CNW-1:0] cnt_q;
	logic [1:0]     drain_q;
	logic           div_start, div_busy, div_done;
	logic [11:0]    q0, q1, q2;
	logic           take;

	assign div_start = state_q == S_DRAIN && drain_q == 2'd0;
	assign take      = state_q == S_DIV && div_done && (!out_valid || out_ready);

	gead_div #(.SW(SW), .CNW(CNW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num0   (sr_q),
		.num1   (sg_q),
		.num2   (sb_q),
		.den    (cnt_q),
		.busy   (div_busy),
		.done   (div_done),
		.q0     (q0),
		.q1     (q1),
		.q2     (q2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rd_v_s1   <= 1'b0;
			drain_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			rd_v_s1 <= state_q == S_WALK && inb;
			if (take) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (filt_in) state_q <= S_CEN;
				end
				S_CEN: state_q <= S_WALK;
				S_WALK: begin
					if (last) begin
						state_q <= S_DRAIN;
						drain_q <= 2'd3;
					end
				end
				S_DRAIN: begin
					if (drain_q == 2'd0) state_q <= S_DIV;
					else drain_q <= drain_q - 1'b1;
				end
				S_DIV: begin
					if (take) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (filt_in) begin
			x_q     <= $signed({2'b0, column}) - $signed({7'b0, r});
			y_beg_q <= $signed({2'b0, row}) - $signed({7'b0, r});
			y_q     <= $signed({2'b0, row}) - $signed({7'b0, r});
			x_end_q <= $signed({2'b0, column}) + $signed({7'b0, r});
			y_end_q <= $signed({2'b0, row}) + $signed({7'b0, r});
		end else if (state_q == S_WALK) begin
			if (y_q == y_end_q) begin
				y_q <= y_beg_q;
				x_q <= x_q + 10'sd1;
			end else begin
				y_q <= y_q + 10'sd1;
			end
		end
		if (state_q == S_CEN) begin
			cen_q <= rdata.g;
			sr_q  <= SW'(rdata.colour[35:24]);
			sg_q  <= SW'(rdata.colour[23:12]);
			sb_q  <= SW'(rdata.colour[11:0]);
			cnt_q <= CNW'(1);
		end else if (res.v) begin
			sr_q  <= sr_q + SW'(res.colour[35:24]);
			sg_q  <= sg_q + SW'(res.colour[23:12]);
			sb_q  <= sb_q + SW'(res.colour[11:0]);
			cnt_q <= cnt_q + 1'b1;
		end
		if (take) begin
			avg_red      <= q0;
			avg_green    <= q1;
			avg_blue     <= q2;
			contributors <= 8'(cnt_q);
		end
	end

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> cnt_q != '0)
		else $error("divide by zero count");

	a_div_from_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(div_busy) |-> $past(state_q) == S_DRAIN)
		else $error("divider started outside drain");

	a_no_late_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> !res.v && !rd_v_s1)
		else $error("sample arrived after drain");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> 32'(cnt_q) <= CMAX)
		else $error("contributor count overflow");

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for guided_edge_aware_denoise: guide frame loads and filter beats.
// Holds its own predictor of the window average, in a small scoreboard class.
// Depends on gead_pkg and the guided_edge_aware_denoise RTL.
module tb_top import gead_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [11:0] r, g, b;
		logic [7:0]  cnt;
	} avg_t;

	class denoise_sb;
		logic [35:0] colour_mem [65536];
		logic [35:0] albedo_mem [65536];
		logic [47:0] normal_mem [65536];
		logic [23:0] depth_mem  [65536];
		logic [15:0] id_mem     [65536];
		int unsigned rad, alb_thr, dep_thr, fw, fh;
		int          ncos;
		avg_t        pending[$];

		function new();
			rad = 1; ncos = 14189; alb_thr = 1024; dep_thr = 4096; fw = 256; fh = 256;
		endfunction

		function void set_reg(logic [2:0] idx, logic [25:0] val);
			case (idx)
				REG_RADIUS:    rad = 32'(val[2:0]);
				REG_NCOS:      ncos = 32'($signed(val[15:0]));
				REG_ALB_SQ:    alb_thr = 32'(val);
				REG_DEPTH_THR: dep_thr = 32'(val[23:0]);
				REG_WIDTH:     fw = 32'(val[8:0]);
				REG_HEIGHT:    fh = 32'(val[8:0]);
				default: ;
			endcase
		endfunction

		function bit neighbor_ok(int c, int k);
			longint dd, alb_dist, d, dot;
			if (id_mem[k] != id_mem[c]) return 0;
			dd = longint'(depth_mem[k]) - longint'(depth_mem[c]);
			if (dd < 0) dd = -dd;
			if (dd > dep_thr) return 0;
			alb_dist = 0;
			for (int s = 0; s < 36; s += 12) begin
				d = longint'((albedo_mem[k] >> s) & 36'hFFF) - longint'((albedo_mem[c] >> s) & 36'hFFF);
				alb_dist += d * d;
			end
			if (alb_dist > alb_thr) return 0;
			dot = 0;
			for (int s = 0; s < 48; s += 16)
				dot += longint'($signed(16'(normal_mem[k] >> s)))
					* longint'($signed(16'(normal_mem[c] >> s)));
			if (dot < 0) return 0;
			if (dot < longint'(ncos) * 16384) return 0;
			return 1;
		endfunction

		function void note_beat(logic op, logic [7:0] col, logic [7:0] row,
				logic [35:0] clr, logic [35:0] alb, logic [47:0] nrm,
				logic [23:0] dep, logic [15:0] id);
			int w, h, r, c, k;
			longint sr, sg, sb2, cnt;
			avg_t e;
			c = row * 256 + col;
			if (op == OP_LOAD) begin
				colour_mem[c] = clr; albedo_mem[c] = alb; normal_mem[c] = nrm;
				depth_mem[c] = dep; id_mem[c] = id;
				return;
			end
			w = fw < 256 ? fw : 256;
			h = fh < 256 ? fh : 256;
			if (col >= w || row >= h) return;
			r = rad < 7 ? rad : 7;
			sr = colour_mem[c][35:24]; sg = colour_mem[c][23:12]; sb2 = colour_mem[c][11:0];
			cnt = 1;
			for (int x = int'(col) - r; x <= int'(col) + r; x++)
				for (int y = int'(row) - r; y <= int'(row) + r; y++) begin
					if (x < 0 || y < 0 || x >= w || y >= h) continue;
					k = y * 256 + x;
					if (!neighbor_ok(c, k)) continue;
					sr += colour_mem[k][35:24];
					sg += colour_mem[k][23:12];
					sb2 += colour_mem[k][11:0];
					cnt++;
				end
			e.r = 12'(sr / cnt); e.g = 12'(sg / cnt); e.b = 12'(sb2 / cnt); e.cnt = 8'(cnt);
			pending = {pending, e};
		endfunction

		function string check_result(avg_t got);
			avg_t e;
			if (pending.size() == 0) return $sformatf("unexpected result %p", got);
			e = pending.pop_front();
			if (got.r !== e.r || got.g !== e.g || got.b !== e.b || got.cnt !== e.cnt)
				return $sformatf("result mismatch got %p exp %p", got, e);
			return "";
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, operation = 0;
	logic [7:0] column = 0, row = 0;
	logic [11:0] red = 0, green = 0, blue = 0;
	logic [35:0] albedo_packed = 0;
	logic [47:0] normal_packed = 0;
	logic [23:0] depth = 0;
	logic [15:0] object_id = 0;
	logic out_ready = 0, cfg_valid = 0;
	logic [2:0] cfg_index = 0;
	logic [25:0] cfg_data = 0;
	logic in_ready, out_valid, cfg_ready;
	logic [11:0] avg_red, avg_green, avg_blue;
	logic [7:0] contributors;

	guided_edge_aware_denoise dut (.*);

	always #4 clk = ~clk;

	denoise_sb sb = new();
	int errs = 0;
	int hold_off = 0;
	int burst_left = 0;
	bit gaps_on = 1;
	bit loaded [65536];
	// base guide values so that neighbors tend to pass the tests
	logic [11:0] b_alb;
	logic [15:0] b_nx, b_ny, b_nz, b_id;
	logic [23:0] b_dep;

	task automatic report(string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		errs++;
	endtask

	// receiver: own stall pattern plus a long hold-off on request
	always @(posedge clk) begin
		int cyc;
		avg_t got;
		string msg;
		if (out_valid && out_ready) begin
			got.r = avg_red; got.g = avg_green; got.b = avg_blue; got.cnt = contributors;
			msg = sb.check_result(got);
			if (msg != "") report(msg);
		end
		cyc = cyc + 1;
		if (hold_off > 0) begin
			hold_off--;
			out_ready <= 0;
		end else if ((cyc / 500) % 3 == 0)
			out_ready <= 1;
		else if ((cyc / 500) % 3 == 1)
			out_ready <= ($urandom_range(0, 9) < 6);
		else
			out_ready <= (cyc % 7) < 3;
	end

	task automatic write_reg(logic [2:0] idx, logic [25:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic send_beat(logic op, logic [7:0] col, logic [7:0] rw, logic [35:0] clr,
			logic [35:0] alb, logic [47:0] nrm, logic [23:0] dep, logic [15:0] id);
		int gap;
		operation <= op; column <= col; row <= rw;
		red <= clr[35:24]; green <= clr[23:12]; blue <= clr[11:0];
		albedo_packed <= alb; normal_packed <= nrm; depth <= dep; object_id <= id;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		sb.note_beat(op, col, rw, clr, alb, nrm, dep, id);
		if (op == OP_LOAD) loaded[rw * 256 + col] = 1;
		if (burst_left > 0)
			burst_left--;
		else begin
			burst_left = $urandom_range(1, 30);
			gap = gaps_on ? $urandom_range(0, 20) : 0;
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	function automatic logic [15:0] near16(logic [15:0] base, int spread);
		return base + 16'($urandom_range(0, 2 * spread)) - 16'(spread);
	endfunction

	task automatic load_pixel(logic [7:0] col, logic [7:0] rw);
		logic [35:0] alb;
		logic [47:0] nrm;
		logic [23:0] dep;
		logic [15:0] id;
		int m;
		m = $urandom_range(0, 19);
		if (m == 0) begin
			// fully random: every bit of every field moves
			alb = 36'({$urandom, $urandom}); nrm = 48'({$urandom, $urandom});
			dep = 24'($urandom); id = 16'($urandom);
		end else begin
			alb = {12'(near16(16'(b_alb), 12)), 12'(near16(16'(b_alb), 12)),
				12'(near16(16'(b_alb), 12))};
			nrm = {near16(b_nx, 600), near16(b_ny, 600), near16(b_nz, 600)};
			if (m == 1) nrm = '0;
			dep = m == 2 ? 24'hFFFFFF : b_dep + 24'($urandom_range(0, 6000));
			id = b_id + 16'($urandom_range(0, m == 3 ? 1 : 0));
		end
		send_beat(OP_LOAD, col, rw, 36'({$urandom, $urandom}), alb, nrm, dep, id);
	endtask

	task automatic drain(int extra);
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic new_setting(int r, int nc, int al, int dp, int w, int h);
		int ww, hh;
		drain(400);
		write_reg(REG_RADIUS, 26'(r));
		write_reg(REG_NCOS, 26'(nc) & 26'hFFFF);
		write_reg(REG_ALB_SQ, 26'(al));
		write_reg(REG_DEPTH_THR, 26'(dp));
		write_reg(REG_WIDTH, 26'(w));
		write_reg(REG_HEIGHT, 26'(h));
		b_alb = 12'($urandom); b_id = 16'($urandom); b_dep = 24'($urandom);
		b_nx = 16'sd9000; b_ny = 16'(-4000); b_nz = 16'sd12000;
		if ($urandom_range(0, 1)) begin
			b_nx = 16'sd16384; b_ny = 0; b_nz = 0;
		end
		ww = w < 256 ? w : 256;
		hh = h < 256 ? h : 256;
		for (int y = 0; y < hh; y++)
			for (int x = 0; x < ww; x++)
				if (!loaded[y * 256 + x]) load_pixel(8'(x), 8'(y));
	endtask

	task automatic random_items(int n);
		int w, h, m;
		w = sb.fw < 256 ? sb.fw : 256;
		h = sb.fh < 256 ? sb.fh : 256;
		for (int i = 0; i < n; i++) begin
			m = $urandom_range(0, 19);
			if (m < 12)
				send_beat(OP_FILTER, 8'($urandom_range(0, w - 1)), 8'($urandom_range(0, h - 1)),
					36'({$urandom, $urandom}), 36'({$urandom, $urandom}),
					48'({$urandom, $urandom}), 24'($urandom), 16'($urandom));
			else if (m < 15)
				send_beat(OP_FILTER, 8'($urandom), 8'($urandom), 36'({$urandom, $urandom}),
					36'({$urandom, $urandom}), 48'({$urandom, $urandom}),
					24'($urandom), 16'($urandom));
			else if (m < 18)
				load_pixel(8'($urandom_range(0, w - 1)), 8'($urandom_range(0, h - 1)));
			else
				load_pixel(8'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		b_alb = 12'h800; b_id = 16'h0005; b_dep = 24'h001000;
		b_nx = 16'sd16384; b_ny = 0; b_nz = 0;
		// directed: 4x4 frame with extreme and special pixels
		new_setting(1, 14189, 1024, 4096, 4, 4);
		send_beat(OP_LOAD, 0, 0, 36'hFFF_FFF_FFF, 36'h800800800, {16'sd16384, 32'h0},
			24'h001000, 16'h0005);
		send_beat(OP_LOAD, 1, 0, 36'h000_000_000, 36'h800800800, {16'sd16384, 32'h0},
			24'h001000, 16'h0005);
		send_beat(OP_LOAD, 1, 1, 36'hFFF_000_FFF, 36'h800800800, 48'h0, 24'h001000, 16'h0005);
		send_beat(OP_LOAD, 2, 1, 36'h123_456_789, 36'h800800800, {16'sd16384, 32'h0},
			24'h001000, 16'hFFFF);
		send_beat(OP_LOAD, 0, 1, 36'hABC_DEF_012, 36'hFFF000FFF, {16'sd16384, 32'h0},
			24'hFFFFFF, 16'h0005);
		send_beat(OP_LOAD, 3, 3, 36'hFFF_FFF_FFF, 36'h800800800, {16'(-16384), 32'h0},
			24'h001000, 16'h0005);
		send_beat(OP_LOAD, 255, 255, 36'h0, 36'h0, 48'hFFFF_FFFF_FFFF, 24'h0, 16'h0);
		for (int y = 0; y < 4; y++)
			for (int x = 0; x < 4; x++)
				send_beat(OP_FILTER, 8'(x), 8'(y), '0, '0, '0, '0, '0);
		send_beat(OP_FILTER, 4, 0, '0, '0, '0, '0, '0);
		send_beat(OP_FILTER, 0, 200, '0, '0, '0, '0, '0);
		new_setting(0, -16384, 0, 0, 8, 8);
		random_items(40);
		new_setting(7, 16384, 50307075, 16777215, 12, 12);
		random_items(40);
		new_setting(7, 0, 50307075, 16777215, 12, 12);
		hold_off = 3000; // receiver holds off while filters keep coming
		random_items(40);
		new_setting(3, 8000, 4000, 1000, 1, 1);
		random_items(20);
		new_setting(7, -100, 60000, 60000, 40, 1);
		random_items(40);
		new_setting(2, -5000, 20000, 20000, 12, 10);
		random_items(40);
		drain(0); // sender pauses until every result is back
		gaps_on = 0;
		random_items(40);
		gaps_on = 1;
		new_setting(5, 14189, 1024, 4096, 14, 14);
		random_items(60);
		new_setting(1, 14189, 1024, 4096, 1, 40);
		random_items(40);
		drain(400);
		if (sb.pending.size() != 0) report("expected results left over");
		if (errs == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
